// ===== sv/assert_macros.svh =====
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== sv/des_pkg.sv =====
package des_pkg;

    localparam int NumRounds = 16;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ROUND = 3'b010,
        ST_DONE  = 3'b100
    } des_state_t;

    typedef struct packed {
        logic load;
        logic round;
        logic [3:0] round_idx;
    } des_cmd_t;

    localparam logic [6:0] TAB_IP [64] = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
    localparam logic [6:0] TAB_FP [64] = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
    localparam logic [5:0] TAB_E [48] = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29,
        28,29,30,31,32,1};
    localparam logic [5:0] TAB_P [32] = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};
    localparam logic [6:0] TAB_PC1 [56] = '{
        57,49,41,33,25,17,9,  1,58,50,42,34,26,18,
        10,2,59,51,43,35,27,  19,11,3,60,52,44,36,
        63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
        14,6,61,53,45,37,29,  21,13,5,28,20,12,4};
    localparam logic [5:0] TAB_PC2 [48] = '{
        14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
        41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53,
        46,42,50,36,29,32};
    localparam logic [1:0] TAB_ROT [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
    localparam logic [3:0] TAB_S [8][64] = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
          0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
          15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
          3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
          13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
          13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
          1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
          13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
          3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
          14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
          11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
          10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
          4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
          13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
          6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
          1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
          2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

    function automatic logic [63:0] perm_ip(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64-TAB_IP[i]];
        return r;
    endfunction

    function automatic logic [63:0] perm_fp(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64-TAB_FP[i]];
        return r;
    endfunction

    function automatic logic [55:0] perm_pc1(input logic [63:0] v);
        logic [55:0] r;
        for (int i = 0; i < 56; i++) r[55-i] = v[64-TAB_PC1[i]];
        return r;
    endfunction

    function automatic logic [47:0] perm_pc2(input logic [55:0] v);
        logic [47:0] r;
        for (int i = 0; i < 48; i++) r[47-i] = v[56-TAB_PC2[i]];
        return r;
    endfunction

    function automatic logic [27:0] rot28(input logic [27:0] c, input logic [1:0] s);
        return (s == 2'd2) ? {c[25:0], c[27:26]} : {c[26:0], c[27]};
    endfunction

    function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
        logic [47:0] e;
        logic [31:0] s;
        logic [31:0] p;
        logic [5:0] six;
        for (int i = 0; i < 48; i++) e[47-i] = r[32-TAB_E[i]];
        e = e ^ k;
        for (int j = 0; j < 8; j++) begin
            six = e[47-6*j -: 6];
            s[31-4*j -: 4] = TAB_S[j][{six[5], six[0], six[4:1]}];
        end
        for (int i = 0; i < 32; i++) p[31-i] = s[32-TAB_P[i]];
        return p;
    endfunction

endpackage

// ===== sv/des_key_sched.sv =====
module des_key_sched (
    input  logic        clk,
    input  logic [63:0] cfg_key,
    input  logic        key_we,
    input  logic [3:0]  rd_idx,
    output logic [47:0] round_key
);
    import des_pkg::*;

    logic [55:0] cd;
    logic [27:0] c_all [17];
    logic [27:0] d_all [17];
    logic [47:0] keys_reg [16];

    // reset value of all-zero key gives all-zero round keys: no clear needed
    always_comb
    begin
        cd = perm_pc1(cfg_key);
        c_all[0] = cd[55:28];
        d_all[0] = cd[27:0];
        for (int i = 0; i < 16; i++)
        begin
            c_all[i+1] = rot28(c_all[i], TAB_ROT[i]);
            d_all[i+1] = rot28(d_all[i], TAB_ROT[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            for (int i = 0; i < 16; i++)
                keys_reg[i] <= perm_pc2({c_all[i+1], d_all[i+1]});
        end
    end

    assign round_key = keys_reg[rd_idx];
endmodule

// ===== sv/des_datapath.sv =====
module des_datapath (
    input  logic              clk,
    input  des_pkg::des_cmd_t cmd,
    input  logic [63:0]       block_in,
    input  logic [47:0]       round_key,
    output logic [63:0]       block_out
);
    import des_pkg::*;

    logic [31:0] l_reg, r_reg;
    logic [63:0] ip;

    assign ip = perm_ip(block_in);
    assign block_out = perm_fp({r_reg, l_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            l_reg <= ip[63:32];
            r_reg <= ip[31:0];
        end
        else if (cmd.round)
        begin
            l_reg <= r_reg;
            r_reg <= l_reg ^ feistel(r_reg, round_key);
        end
    end
endmodule

// ===== sv/des_ctrl.sv =====
module des_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              dir,
    output logic              busy,
    output logic              done,
    output des_pkg::des_cmd_t cmd
);
    import des_pkg::*;

    des_state_t state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        cmd.load = 1'b0;
        cmd.round = 1'b0;
        cmd.round_idx = dir ? ~cnt_reg : cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(NumRounds - 1)) state_next = ST_DONE;
            end
            ST_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

// ===== sv/des_block_cipher.sv =====
// done strobe rises after the accepted start: load while idle, then the rounds, one round per cycle
// a new block is accepted only while idle, after done; one feistel round per cycle over 16 stored round keys
// block_out is valid from the cycle done is high until the next accepted start; receiver cannot stall
// rst_n asynchronous active low: idle, direction 0, round keys of the all-zero key
module des_block_cipher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic [63:0] block_in,
    output logic [63:0] block_out,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);
    import des_pkg::*;
    `include "assert_macros.svh"

    des_cmd_t cmd;
    logic direction_reg;
    logic key_we;
    logic [47:0] round_key;
    logic [63:0] key_mux;

    // key store reset: zero key expands to zero round keys, loaded by write at reset exit
    logic key_valid_reg;
    assign key_we = (cfg_we && !cfg_index) || !key_valid_reg;
    assign key_mux = (cfg_we && !cfg_index) ? cfg_data : 64'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
            key_valid_reg <= 1'b0;
        end
        else
        begin
            key_valid_reg <= 1'b1;
            if (cfg_we && cfg_index) direction_reg <= cfg_data[0];
        end
    end

    des_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .dir(direction_reg),
        .busy(busy), .done(done), .cmd(cmd)
    );

    des_key_sched u_keys (
        .clk(clk), .cfg_key(key_mux), .key_we(key_we),
        .rd_idx(cmd.round_idx), .round_key(round_key)
    );

    des_datapath u_dp (
        .clk(clk), .cmd(cmd), .block_in(block_in),
        .round_key(round_key), .block_out(block_out)
    );

    `ASSERT_NEVER(a_load_round, clk, rst_n, cmd.load && cmd.round)
    `ASSERT_IMPL(a_done_pulse, clk, rst_n, done |=> !done)
    `ASSERT_IMPL(a_start_busy, clk, rst_n, (start && !busy) |=> busy)
endmodule
